FILE: hdl/nsfp_pkg.sv
// shared types, constants and helper functions for the nmea sentence field parser
// no dependencies; used by nsfp_core, nsfp_result_queue and nmea_sentence_field_parser

package nsfp_pkg;

  // default sizing, handed to the top level parameters
  localparam int DEFAULT_MAX_FIELDS      = 24;
  localparam int DEFAULT_MAX_FIELD_CHARS = 16;
  localparam int DEFAULT_FRACTION_DIGITS = 5;

  // characters of interest
  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_POINT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  // sentence kinds
  localparam logic [3:0] KIND_UNKNOWN = 4'd0;
  localparam logic [3:0] KIND_GGA     = 4'd1;
  localparam logic [3:0] KIND_GLL     = 4'd2;
  localparam logic [3:0] KIND_RMC     = 4'd3;
  localparam logic [3:0] KIND_VTG     = 4'd4;
  localparam logic [3:0] KIND_GSA     = 4'd5;
  localparam logic [3:0] KIND_GSV     = 4'd6;
  localparam logic [3:0] KIND_ZDA     = 4'd7;
  localparam logic [3:0] KIND_GBS     = 4'd8;

  localparam int NUM_KINDS = 8;
  localparam int KIND_CHARS = 5;

  // address field text, first character in the top byte
  localparam logic [39:0] KIND_NAMES [NUM_KINDS] = '{
    "GPGGA", "GPGLL", "GPRMC", "GPVTG", "GPGSA", "GPGSV", "GPZDA", "GPGBS"
  };

  // token roles
  localparam logic [1:0] ROLE_TOKEN = 2'd0;
  localparam logic [1:0] ROLE_PDOP  = 2'd1;
  localparam logic [1:0] ROLE_HDOP  = 2'd2;
  localparam logic [1:0] ROLE_VDOP  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
  localparam logic [1:0] ERR_NO_DOLLAR = 2'd2;

  localparam int MAX_RESULTS = 4;
  localparam int DOP_DEPTH   = 3;

  typedef enum logic [1:0] {
    MODE_WAIT,
    MODE_LINE,
    MODE_SKIP
  } line_mode_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_WHOLE,
    PH_FRAC,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic [3:0]  sentence_kind;
    logic [4:0]  token_index;
    logic [1:0]  role;
    logic        is_empty;
    logic [7:0]  lead_char;
    logic        is_negative;
    logic [31:0] whole_part;
    logic [16:0] fraction_part;
    logic [1:0]  error_code;
    logic        end_of_line;
  } result_t;

  // up to four results caused by one character
  typedef struct packed {
    logic [2:0]                    count;
    result_t [MAX_RESULTS-1:0]     res;
  } batch_t;

  // one remembered non-empty token for the dilution outputs
  typedef struct packed {
    logic        neg;
    logic [31:0] whole;
    logic [16:0] frac;
  } dop_t;

  function automatic logic [3:0] kind_match(logic [39:0] chars);
    logic [3:0] k;
    k = KIND_UNKNOWN;
    for (int i = NUM_KINDS - 1; i >= 0; i--) begin
      if (chars == KIND_NAMES[i]) k = 4'(i + 1);
    end
    return k;
  endfunction

  function automatic logic [31:0] pow10(logic [3:0] n);
    logic [31:0] p;
    case (n)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

FILE: hdl/nsfp_core.sv
// line and token state plus the per-character result logic
// depends on nsfp_pkg; drives a batch of up to four results per character

module nsfp_core #(
  parameter int MAX_FIELDS      = nsfp_pkg::DEFAULT_MAX_FIELDS,
  parameter int MAX_FIELD_CHARS = nsfp_pkg::DEFAULT_MAX_FIELD_CHARS,
  parameter int FRACTION_DIGITS = nsfp_pkg::DEFAULT_FRACTION_DIGITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       char_byte,
  input  logic             take,
  output nsfp_pkg::batch_t batch
);

  localparam int POS_W  = $clog2(MAX_FIELDS + 1);
  localparam int CNT_W  = $clog2(MAX_FIELD_CHARS + 1);
  localparam int FRAC_W = $clog2(10 ** FRACTION_DIGITS);
  localparam int FD_W   = $clog2(FRACTION_DIGITS + 1);

  nsfp_pkg::line_mode_t mode, mode_next;
  logic [POS_W-1:0]     pos, pos_next;
  logic [CNT_W-1:0]     char_count, char_count_next;
  logic [39:0]          kind_chars, kind_chars_next;
  logic [3:0]           kind_code, kind_code_next;
  logic [31:0]          whole_accum, whole_accum_next;
  logic [FRAC_W-1:0]    frac_accum, frac_accum_next;
  logic [FD_W-1:0]      frac_digits, frac_digits_next;
  logic [7:0]           lead, lead_next;
  nsfp_pkg::phase_t     phase, phase_next;
  nsfp_pkg::dop_t [nsfp_pkg::DOP_DEPTH-1:0] hist, hist_next, hist_after, dop_src;
  logic [1:0]           dop_count, dop_count_next, dop_after, dop_src_count;

  logic        is_eol, is_digit, tok_empty, tok_neg, last_tok, too_long, closing;
  logic [3:0]  digit, kind_now;
  logic [31:0] scaled;
  logic [35:0] whole_mul;
  nsfp_pkg::dop_t new_entry;
  nsfp_pkg::result_t [nsfp_pkg::DOP_DEPTH-1:0] dop_res;

  assign is_eol   = (char_byte == nsfp_pkg::CHAR_NEWLINE) || (char_byte == nsfp_pkg::CHAR_NUL);
  assign is_digit = (char_byte >= nsfp_pkg::CHAR_ZERO) && (char_byte <= nsfp_pkg::CHAR_NINE);
  assign digit    = 4'(char_byte - nsfp_pkg::CHAR_ZERO);

  assign tok_empty = (char_count == '0);
  assign tok_neg   = (lead == nsfp_pkg::CHAR_MINUS);
  assign kind_now  = (pos == '0) ? nsfp_pkg::kind_match(kind_chars) : kind_code;
  assign last_tok  = is_eol || (pos >= POS_W'(MAX_FIELDS - 1));
  assign too_long  = (char_count >= CNT_W'(MAX_FIELD_CHARS - 1));
  assign closing   = is_eol || (char_byte == nsfp_pkg::CHAR_COMMA);

  // pad the fraction out to the full digit count
  assign scaled = 32'(frac_accum)
                * nsfp_pkg::pow10(4'(FRACTION_DIGITS - int'(frac_digits)));
  assign whole_mul = {4'b0, whole_accum} * 36'd10 + 36'(digit);

  assign new_entry = '{neg: tok_neg, whole: whole_accum, frac: scaled[16:0]};

  // history as it stands once the closing token is counted
  always_comb begin
    hist_after = hist;
    dop_after  = dop_count;
    if (!tok_empty) begin
      hist_after[0] = hist[1];
      hist_after[1] = hist[2];
      hist_after[2] = new_entry;
      dop_after     = (dop_count == 2'd3) ? 2'd3 : dop_count + 2'd1;
    end
  end

  assign dop_src       = closing ? hist_after : hist;
  assign dop_src_count = closing ? dop_after : dop_count;

  always_comb begin
    for (int r = 0; r < nsfp_pkg::DOP_DEPTH; r++) begin
      logic ok;
      nsfp_pkg::dop_t e;
      ok = (dop_src_count >= 2'(nsfp_pkg::DOP_DEPTH - r));
      e  = ok ? dop_src[r] : '0;
      dop_res[r]               = '0;
      dop_res[r].sentence_kind = nsfp_pkg::KIND_GSA;
      dop_res[r].role          = 2'(nsfp_pkg::ROLE_PDOP + 2'(r));
      dop_res[r].is_empty      = !ok;
      dop_res[r].is_negative   = e.neg;
      dop_res[r].whole_part    = e.whole;
      dop_res[r].fraction_part = e.frac;
      dop_res[r].error_code    = nsfp_pkg::ERR_NONE;
      dop_res[r].end_of_line   = (r == nsfp_pkg::DOP_DEPTH - 1);
    end
  end

  always_comb begin
    mode_next        = mode;
    pos_next         = pos;
    char_count_next  = char_count;
    kind_chars_next  = kind_chars;
    kind_code_next   = kind_code;
    whole_accum_next = whole_accum;
    frac_accum_next  = frac_accum;
    frac_digits_next = frac_digits;
    lead_next        = lead;
    phase_next       = phase;
    hist_next        = hist;
    dop_count_next   = dop_count;
    batch            = '0;

    unique case (mode)
      nsfp_pkg::MODE_WAIT: begin
        if (char_byte == nsfp_pkg::CHAR_DOLLAR) begin
          mode_next        = nsfp_pkg::MODE_LINE;
          pos_next         = '0;
          kind_code_next   = nsfp_pkg::KIND_UNKNOWN;
          kind_chars_next  = '0;
          hist_next        = '0;
          dop_count_next   = '0;
          char_count_next  = CNT_W'(1);
          whole_accum_next = '0;
          frac_accum_next  = '0;
          frac_digits_next = '0;
          lead_next        = nsfp_pkg::CHAR_DOLLAR;
          phase_next       = nsfp_pkg::PH_STOP;
        end else begin
          batch.count                  = 3'd1;
          batch.res[0].error_code      = nsfp_pkg::ERR_NO_DOLLAR;
          batch.res[0].end_of_line     = 1'b1;
          mode_next = is_eol ? nsfp_pkg::MODE_WAIT : nsfp_pkg::MODE_SKIP;
        end
      end
      nsfp_pkg::MODE_SKIP: begin
        if (is_eol) mode_next = nsfp_pkg::MODE_WAIT;
      end
      nsfp_pkg::MODE_LINE: begin
        if (closing) begin
          if (pos == '0) kind_code_next = kind_now;
          hist_next      = hist_after;
          dop_count_next = dop_after;
          batch.count                 = 3'd1;
          batch.res[0].sentence_kind  = kind_now;
          batch.res[0].token_index    = 5'(pos);
          batch.res[0].role           = nsfp_pkg::ROLE_TOKEN;
          batch.res[0].is_empty       = tok_empty;
          batch.res[0].lead_char      = lead;
          batch.res[0].is_negative    = tok_neg;
          batch.res[0].whole_part     = whole_accum;
          batch.res[0].fraction_part  = scaled[16:0];
          batch.res[0].error_code     = nsfp_pkg::ERR_NONE;
          batch.res[0].end_of_line    = last_tok && (kind_now != nsfp_pkg::KIND_GSA);
          if (last_tok && (kind_now == nsfp_pkg::KIND_GSA)) begin
            batch.count  = 3'd4;
            batch.res[1] = dop_res[0];
            batch.res[2] = dop_res[1];
            batch.res[3] = dop_res[2];
          end
          pos_next         = pos + POS_W'(1);
          char_count_next  = '0;
          whole_accum_next = '0;
          frac_accum_next  = '0;
          frac_digits_next = '0;
          lead_next        = '0;
          phase_next       = nsfp_pkg::PH_START;
          if (last_tok) mode_next = is_eol ? nsfp_pkg::MODE_WAIT : nsfp_pkg::MODE_SKIP;
        end else if (too_long) begin
          batch.count                = 3'd1;
          batch.res[0].sentence_kind = kind_code;
          batch.res[0].token_index   = 5'(pos);
          batch.res[0].error_code    = nsfp_pkg::ERR_TOO_LONG;
          batch.res[0].end_of_line   = (kind_code != nsfp_pkg::KIND_GSA);
          if (kind_code == nsfp_pkg::KIND_GSA) begin
            batch.count  = 3'd4;
            batch.res[1] = dop_res[0];
            batch.res[2] = dop_res[1];
            batch.res[3] = dop_res[2];
          end
          mode_next = nsfp_pkg::MODE_SKIP;
        end else begin
          if (char_count == '0) lead_next = char_byte;
          if ((pos == '0) && (char_count >= CNT_W'(1))
              && (char_count <= CNT_W'(nsfp_pkg::KIND_CHARS))) begin
            kind_chars_next[8*(nsfp_pkg::KIND_CHARS - int'(char_count)) +: 8] = char_byte;
          end
          case (phase)
            nsfp_pkg::PH_START: begin
              if ((char_byte == nsfp_pkg::CHAR_MINUS) || (char_byte == nsfp_pkg::CHAR_PLUS)
                  || is_digit) begin
                phase_next = nsfp_pkg::PH_WHOLE;
              end else if (char_byte == nsfp_pkg::CHAR_POINT) begin
                phase_next = nsfp_pkg::PH_FRAC;
              end else begin
                phase_next = nsfp_pkg::PH_STOP;
              end
              if (is_digit) whole_accum_next = 32'(digit);
            end
            nsfp_pkg::PH_WHOLE: begin
              if (is_digit) begin
                // saturate at all ones
                whole_accum_next = (whole_mul[35:32] != 4'd0) ? '1 : whole_mul[31:0];
              end else if (char_byte == nsfp_pkg::CHAR_POINT) begin
                phase_next = nsfp_pkg::PH_FRAC;
              end else begin
                phase_next = nsfp_pkg::PH_STOP;
              end
            end
            nsfp_pkg::PH_FRAC: begin
              if (is_digit) begin
                if (frac_digits < FD_W'(FRACTION_DIGITS)) begin
                  frac_accum_next  = FRAC_W'(frac_accum * FRAC_W'(10) + FRAC_W'(digit));
                  frac_digits_next = frac_digits + FD_W'(1);
                end
              end else begin
                phase_next = nsfp_pkg::PH_STOP;
              end
            end
            default: ;
          endcase
          char_count_next = char_count + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= nsfp_pkg::MODE_WAIT;
      pos         <= '0;
      char_count  <= '0;
      kind_chars  <= '0;
      kind_code   <= nsfp_pkg::KIND_UNKNOWN;
      whole_accum <= '0;
      frac_accum  <= '0;
      frac_digits <= '0;
      lead        <= '0;
      phase       <= nsfp_pkg::PH_START;
      hist        <= '0;
      dop_count   <= '0;
    end else if (take) begin
      mode        <= mode_next;
      pos         <= pos_next;
      char_count  <= char_count_next;
      kind_chars  <= kind_chars_next;
      kind_code   <= kind_code_next;
      whole_accum <= whole_accum_next;
      frac_accum  <= frac_accum_next;
      frac_digits <= frac_digits_next;
      lead        <= lead_next;
      phase       <= phase_next;
      hist        <= hist_next;
      dop_count   <= dop_count_next;
    end
  end

  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    (take && (mode == nsfp_pkg::MODE_SKIP)) |-> (batch.count == 3'd0))
    else $error("skipped line produced a result");

  a_four_ends_gsa: assert property (@(posedge clk) disable iff (rst)
    (take && (batch.count == 3'd4)) |->
      (batch.res[3].end_of_line && (batch.res[3].role == nsfp_pkg::ROLE_VDOP)))
    else $error("four-result batch does not end with vdop");

  a_wait_after_eol: assert property (@(posedge clk) disable iff (rst)
    (take && is_eol) |=> (mode == nsfp_pkg::MODE_WAIT))
    else $error("line end did not return to wait");

endmodule

FILE: hdl/nsfp_result_queue.sv
// result register that holds one batch and hands it out one transfer per cycle while ready is high
// depends on nsfp_pkg

module nsfp_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  nsfp_pkg::batch_t  batch,
  output logic              can_load,
  output nsfp_pkg::result_t result,
  output logic              valid,
  input  logic              ready
);

  logic [2:0]        count;
  nsfp_pkg::result_t slot [nsfp_pkg::MAX_RESULTS];
  logic              pop;

  assign valid    = (count != 3'd0);
  assign pop      = valid && ready;
  assign can_load = (count == 3'd0) || ((count == 3'd1) && ready);
  assign result   = slot[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else if (load) begin
      count <= batch.count;
    end else if (pop) begin
      count <= count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < nsfp_pkg::MAX_RESULTS; i++) slot[i] <= batch.res[i];
    end else if (pop) begin
      for (int i = 0; i < nsfp_pkg::MAX_RESULTS - 1; i++) slot[i] <= slot[i+1];
    end
  end

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("batch loaded over undelivered results");

  a_drain_step: assert property (@(posedge clk) disable iff (rst)
    (pop && !load) |=> (count == $past(count) - 3'd1))
    else $error("result count did not step down on transfer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(nsfp_pkg::MAX_RESULTS))
    else $error("result count out of range");

endmodule

FILE: hdl/nmea_sentence_field_parser.sv
// top level of the nmea sentence field parser: input register, core and result queue
// depends on nsfp_pkg, nsfp_core and nsfp_result_queue

// Takes nmea 0183 text one byte per transfer and reports each comma-separated
// token of a line as one result: sentence kind (from the five characters after
// '$'), token index, empty flag, first character, minus flag, saturating
// integer part and a fixed-point fraction of FRACTION_DIGITS digits. A line
// ends at a newline or a zero byte; a line that does not open with '$' (an
// empty line or an idle zero byte included) gives a single error result, and
// a token reaching MAX_FIELD_CHARS characters gives a too-long error and the
// rest of its line is dropped. On gsa lines the last token or a too-long error
// is followed by three more results carrying the last three non-empty tokens
// as pdop, hdop and vdop, end_of_line on the vdop one. The input takes one byte
// per cycle while no byte waits on the queue. A byte causes zero, one or four
// results; results leave one per cycle from the result queue while out_ready
// is high. After a byte that causes four results the input register still
// takes one more byte; if that byte also causes a result it waits there and
// holds the input off while the queue drains. Results are registered in the queue.

module nmea_sentence_field_parser #(
  parameter int MAX_FIELDS      = nsfp_pkg::DEFAULT_MAX_FIELDS,
  parameter int MAX_FIELD_CHARS = nsfp_pkg::DEFAULT_MAX_FIELD_CHARS,
  parameter int FRACTION_DIGITS = nsfp_pkg::DEFAULT_FRACTION_DIGITS
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  sentence_kind,
  output logic [4:0]  token_index,
  output logic [1:0]  role,
  output logic        is_empty,
  output logic [7:0]  lead_char,
  output logic        is_negative,
  output logic [31:0] whole_part,
  output logic [16:0] fraction_part,
  output logic [1:0]  error_code,
  output logic        end_of_line
);

  // input register
  logic              ireg_valid;
  logic [7:0]        ireg_byte;

  logic              core_take;
  logic              q_can_load;
  logic              q_load;
  nsfp_pkg::batch_t  batch;
  nsfp_pkg::result_t result;

  // a byte that causes no result never waits on the queue
  assign core_take = ireg_valid && ((batch.count == 3'd0) || q_can_load);
  assign q_load    = core_take && (batch.count != 3'd0);
  assign in_ready  = !ireg_valid || core_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_ready) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) ireg_byte <= char_byte;
  end

  // line and token state, result formation
  nsfp_core #(
    .MAX_FIELDS      (MAX_FIELDS),
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .char_byte (ireg_byte),
    .take      (core_take),
    .batch     (batch)
  );

  // result register, one result transfer per cycle while out_ready is high
  nsfp_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .load     (q_load),
    .batch    (batch),
    .can_load (q_can_load),
    .result   (result),
    .valid    (out_valid),
    .ready    (out_ready)
  );

  assign sentence_kind = result.sentence_kind;
  assign token_index   = result.token_index;
  assign role          = result.role;
  assign is_empty      = result.is_empty;
  assign lead_char     = result.lead_char;
  assign is_negative   = result.is_negative;
  assign whole_part    = result.whole_part;
  assign fraction_part = result.fraction_part;
  assign error_code    = result.error_code;
  assign end_of_line   = result.end_of_line;

endmodule
